>>> design/assert_macros.svh
// Assertion macros for the design files.
// Depends on nothing; each file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/rca_pkg.sv
// Package for the reference-counted compacting allocator.
// Holds widths, defaults, operation and status codes, and controller types.
package rca_pkg;

    localparam int POOL_BYTES_DEF  = 524288;
    localparam int MAX_OBJECTS_DEF = 256;
    localparam int REF_BITS_DEF    = 16;

    localparam int OP_W   = 3;
    localparam int SIZE_W = 20;
    localparam int ID_W   = 32;
    localparam int STAT_W = 3;
    localparam int AVAIL_W = 21;

    typedef enum logic [OP_W-1:0] {
        OP_INIT     = 3'd0,
        OP_DESTROY  = 3'd1,
        OP_INSERT   = 3'd2,
        OP_RETRIEVE = 3'd3,
        OP_ADD_REF  = 3'd4,
        OP_DROP_REF = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOINIT   = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4,
        ST_AGAIN    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PLACE,
        S_COMPACT,
        S_SCAN,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rotate;
        logic remove;
        logic insert;
    } t_cell_ctl;

endpackage

>>> design/rca_cell.sv
// One table entry of the allocator's cell chain.
// Depends on rca_pkg for the control struct and ID width; loads from its right neighbor.
module rca_cell #(
    parameter int INDEX = 0,
    parameter int FW    = 20,
    parameter int RW    = 16,
    parameter int LW    = 9
) (
    input  logic                          i_clk,
    input  rca_pkg::t_cell_ctl            i_ctl,
    input  logic [LW-1:0]                 i_pos,
    input  logic [LW-1:0]                 i_live,
    input  logic [rca_pkg::ID_W-1:0]      i_nxt_id,
    input  logic [FW-1:0]                 i_nxt_size,
    input  logic [FW-1:0]                 i_nxt_ofs,
    input  logic [RW-1:0]                 i_nxt_refs,
    input  logic [rca_pkg::ID_W-1:0]      i_ins_id,
    input  logic [FW-1:0]                 i_ins_size,
    input  logic [FW-1:0]                 i_ins_ofs,
    output logic [rca_pkg::ID_W-1:0]      o_id,
    output logic [FW-1:0]                 o_size,
    output logic [FW-1:0]                 o_ofs,
    output logic [RW-1:0]                 o_refs
);

    logic [rca_pkg::ID_W-1:0] r_id;
    logic [FW-1:0]            r_size;
    logic [FW-1:0]            r_ofs;
    logic [RW-1:0]            r_refs;
    logic                     w_take;
    logic                     w_ins;

    assign w_ins  = i_ctl.insert && (i_live == LW'(INDEX));
    assign w_take = i_ctl.rotate || (i_ctl.remove && (LW'(INDEX) >= i_pos));

    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_id   <= i_ins_id;
            r_size <= i_ins_size;
            r_ofs  <= i_ins_ofs;
            r_refs <= RW'(1);
        end else if (w_take) begin
            r_id   <= i_nxt_id;
            r_size <= i_nxt_size;
            r_ofs  <= i_nxt_ofs;
            r_refs <= i_nxt_refs;
        end
    end

    assign o_id   = r_id;
    assign o_size = r_size;
    assign o_ofs  = r_ofs;
    assign o_refs = r_refs;

endmodule

>>> design/refcount_compacting_allocator.sv
// Handle table for a two-bank bump pool, held in a ring of MAX_OBJECTS entry cells.
// Init, destroy, unused ops and inserts that fit go to the result without a ring rotation.
// A lookup makes one full rotation of the cell ring.
// A compacting insert adds one full rotation of the ring; one item is in work at a time.
// Synchronous reset clears control state; entry cells hold no reset value.
`include "assert_macros.svh"
module refcount_compacting_allocator #(
    parameter int POOL_BYTES  = rca_pkg::POOL_BYTES_DEF,
    parameter int MAX_OBJECTS = rca_pkg::MAX_OBJECTS_DEF,
    parameter int REF_BITS    = rca_pkg::REF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rca_pkg::OP_W-1:0]      i_op,
    input  logic [rca_pkg::SIZE_W-1:0]    i_alloc_size,
    input  logic [rca_pkg::ID_W-1:0]      i_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rca_pkg::STAT_W-1:0]    o_status,
    output logic [rca_pkg::ID_W-1:0]      o_new_handle,
    output logic [rca_pkg::SIZE_W-1:0]    o_obj_offset,
    output logic                          o_obj_bank,
    output logic                          o_released,
    output logic                          o_compacted
);

    localparam int FW = $clog2(POOL_BYTES + 1);
    localparam int LW = $clog2(MAX_OBJECTS + 1);
    localparam int RW = REF_BITS;
    localparam int AW = rca_pkg::AVAIL_W;
    localparam int IW = rca_pkg::ID_W;
    localparam int SW = rca_pkg::SIZE_W;

    rca_pkg::t_state    r_state, n_state;
    logic               r_ready, n_ready;
    logic [IW-1:0]      r_idc, n_idc;
    logic [FW-1:0]      r_free, n_free;
    logic               r_bank, n_bank;
    logic [LW-1:0]      r_live, n_live;
    logic [LW-1:0]      r_cnt, n_cnt;
    rca_pkg::t_op       r_op, n_op;
    logic [SW-1:0]      r_size, n_size;
    logic [IW-1:0]      r_hdl, n_hdl;
    logic               r_found, n_found;
    logic               r_rem, n_rem;
    logic [LW-1:0]      r_pos, n_pos;
    logic [FW-1:0]      r_sum, n_sum;
    logic               r_comp, n_comp;
    rca_pkg::t_status   r_st, n_st;
    logic [IW-1:0]      r_nh, n_nh;
    logic [SW-1:0]      r_ofs, n_ofs;
    logic               r_rbank, n_rbank;
    logic               r_rel, n_rel;
    logic               r_ovld, n_ovld;
    logic [rca_pkg::STAT_W-1:0] r_o_st, n_o_st;
    logic [IW-1:0]      r_o_nh, n_o_nh;
    logic [SW-1:0]      r_o_ofs, n_o_ofs;
    logic               r_o_bank, n_o_bank;
    logic               r_o_rel, n_o_rel;
    logic               r_o_comp, n_o_comp;

    rca_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0]      w_id   [MAX_OBJECTS];
    logic [FW-1:0]      w_size [MAX_OBJECTS];
    logic [FW-1:0]      w_ofs  [MAX_OBJECTS];
    logic [RW-1:0]      w_refs [MAX_OBJECTS];
    logic [FW-1:0]      w_ofs_tail;
    logic [RW-1:0]      w_refs_tail;
    logic [RW-1:0]      w_dec;
    logic [AW-1:0]      w_avail;
    logic               w_fits;
    logic               w_kvalid;
    logic               w_last;
    logic               w_hit;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_OBJECTS; gi++) begin : g_cell
            if (gi == MAX_OBJECTS - 1) begin : g_tail
                rca_cell #(.INDEX(gi), .FW(FW), .RW(RW), .LW(LW)) u_cell (
                    .i_clk(i_clk), .i_ctl(w_ctl), .i_pos(r_pos), .i_live(r_live),
                    .i_nxt_id(w_id[0]), .i_nxt_size(w_size[0]),
                    .i_nxt_ofs(w_ofs_tail), .i_nxt_refs(w_refs_tail),
                    .i_ins_id(r_idc), .i_ins_size(FW'(r_size)), .i_ins_ofs(r_free),
                    .o_id(w_id[gi]), .o_size(w_size[gi]), .o_ofs(w_ofs[gi]),
                    .o_refs(w_refs[gi])
                );
            end else begin : g_body
                rca_cell #(.INDEX(gi), .FW(FW), .RW(RW), .LW(LW)) u_cell (
                    .i_clk(i_clk), .i_ctl(w_ctl), .i_pos(r_pos), .i_live(r_live),
                    .i_nxt_id(w_id[gi+1]), .i_nxt_size(w_size[gi+1]),
                    .i_nxt_ofs(w_ofs[gi+1]), .i_nxt_refs(w_refs[gi+1]),
                    .i_ins_id(r_idc), .i_ins_size(FW'(r_size)), .i_ins_ofs(r_free),
                    .o_id(w_id[gi]), .o_size(w_size[gi]), .o_ofs(w_ofs[gi]),
                    .o_refs(w_refs[gi])
                );
            end
        end
    endgenerate

    assign w_avail  = AW'(POOL_BYTES) - AW'(r_free);
    assign w_fits   = (AW'(r_free) <= AW'(POOL_BYTES)) && (AW'(r_size) <= w_avail);
    assign w_kvalid = r_cnt < r_live;
    assign w_last   = r_cnt == LW'(MAX_OBJECTS - 1);
    assign w_hit    = w_kvalid && !r_found && (w_id[0] == r_hdl);
    assign w_dec    = (w_refs[0] != '0) ? w_refs[0] - RW'(1) : w_refs[0];

    always_comb begin
        n_state = r_state;  n_ready = r_ready;  n_idc = r_idc;   n_free = r_free;
        n_bank = r_bank;    n_live = r_live;    n_cnt = r_cnt;   n_op = r_op;
        n_size = r_size;    n_hdl = r_hdl;      n_found = r_found; n_rem = r_rem;
        n_pos = r_pos;      n_sum = r_sum;      n_comp = r_comp; n_st = r_st;
        n_nh = r_nh;        n_ofs = r_ofs;      n_rbank = r_rbank; n_rel = r_rel;
        n_ovld = r_ovld && i_out_stall;
        n_o_st = r_o_st;    n_o_nh = r_o_nh;    n_o_ofs = r_o_ofs;
        n_o_bank = r_o_bank; n_o_rel = r_o_rel; n_o_comp = r_o_comp;
        w_ctl = '0;
        w_ofs_tail  = w_ofs[0];
        w_refs_tail = w_refs[0];
        case (r_state)
            rca_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op = rca_pkg::t_op'(i_op);
                    n_size = i_alloc_size;
                    n_hdl = i_handle;
                    n_st = rca_pkg::ST_OK;
                    n_nh = '0;
                    n_ofs = '0;
                    n_rbank = 1'b0;
                    n_rel = 1'b0;
                    n_comp = 1'b0;
                    n_cnt = '0;
                    n_found = 1'b0;
                    n_rem = 1'b0;
                    n_state = rca_pkg::S_DONE;
                    case (rca_pkg::t_op'(i_op))
                        rca_pkg::OP_INIT: begin
                            if (r_ready) begin
                                n_st = rca_pkg::ST_AGAIN;
                            end else begin
                                n_ready = 1'b1;
                                n_idc = IW'(1);
                                n_free = '0;
                                n_bank = 1'b0;
                                n_live = '0;
                            end
                        end
                        rca_pkg::OP_DESTROY: begin
                            n_ready = 1'b0;
                            n_idc = IW'(1);
                            n_free = '0;
                            n_bank = 1'b0;
                            n_live = '0;
                        end
                        rca_pkg::OP_INSERT: begin
                            if (!r_ready) begin
                                n_st = rca_pkg::ST_NOINIT;
                            end else if (r_live >= LW'(MAX_OBJECTS) || r_idc == '0) begin
                                n_st = rca_pkg::ST_FULL;
                            end else begin
                                n_state = rca_pkg::S_PLACE;
                            end
                        end
                        rca_pkg::OP_RETRIEVE, rca_pkg::OP_ADD_REF,
                        rca_pkg::OP_DROP_REF: begin
                            if (!r_ready) begin
                                n_st = rca_pkg::ST_NOINIT;
                            end else begin
                                n_state = rca_pkg::S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rca_pkg::S_PLACE: begin
                if (w_fits) begin
                    w_ctl.insert = 1'b1;
                    n_live = r_live + LW'(1);
                    n_free = r_free + FW'(r_size);
                    n_idc = r_idc + IW'(1);
                    n_nh = r_idc;
                    n_state = rca_pkg::S_DONE;
                end else if (!r_comp) begin
                    n_comp = 1'b1;
                    n_cnt = '0;
                    n_sum = '0;
                    n_state = rca_pkg::S_COMPACT;
                end else begin
                    n_st = rca_pkg::ST_NOSPACE;
                    n_state = rca_pkg::S_DONE;
                end
            end
            rca_pkg::S_COMPACT: begin
                w_ctl.rotate = 1'b1;
                if (w_kvalid) begin
                    w_ofs_tail = r_sum;
                    n_sum = r_sum + w_size[0];
                end
                if (w_last) begin
                    n_free = n_sum;
                    n_bank = ~r_bank;
                    n_state = rca_pkg::S_PLACE;
                end else begin
                    n_cnt = r_cnt + LW'(1);
                end
            end
            rca_pkg::S_SCAN: begin
                w_ctl.rotate = 1'b1;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_pos = r_cnt;
                    case (r_op)
                        rca_pkg::OP_RETRIEVE: begin
                            n_ofs = SW'(w_ofs[0]);
                            n_rbank = r_bank;
                        end
                        rca_pkg::OP_ADD_REF: begin
                            if (w_refs[0] != '1) begin
                                w_refs_tail = w_refs[0] + RW'(1);
                            end
                        end
                        rca_pkg::OP_DROP_REF: begin
                            w_refs_tail = w_dec;
                            n_rem = (w_dec == '0);
                        end
                        default: begin
                        end
                    endcase
                end
                if (w_last) begin
                    n_state = rca_pkg::S_EVAL;
                end else begin
                    n_cnt = r_cnt + LW'(1);
                end
            end
            rca_pkg::S_EVAL: begin
                if (!r_found) begin
                    n_st = rca_pkg::ST_NOTFOUND;
                end else if (r_rem) begin
                    w_ctl.remove = 1'b1;
                    n_live = r_live - LW'(1);
                    n_rel = 1'b1;
                end
                n_state = rca_pkg::S_DONE;
            end
            rca_pkg::S_DONE: begin
                if (!r_ovld || !i_out_stall) begin
                    n_ovld = 1'b1;
                    n_o_st = r_st;
                    n_o_nh = r_nh;
                    n_o_ofs = r_ofs;
                    n_o_bank = r_rbank;
                    n_o_rel = r_rel;
                    n_o_comp = r_comp;
                    n_state = rca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rca_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rca_pkg::S_IDLE;
            r_ready <= 1'b0;
            r_idc   <= IW'(1);
            r_free  <= '0;
            r_bank  <= 1'b0;
            r_live  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_idc   <= n_idc;
            r_free  <= n_free;
            r_bank  <= n_bank;
            r_live  <= n_live;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;     r_op <= n_op;       r_size <= n_size;   r_hdl <= n_hdl;
        r_found <= n_found; r_rem <= n_rem;     r_pos <= n_pos;     r_sum <= n_sum;
        r_comp <= n_comp;   r_st <= n_st;       r_nh <= n_nh;       r_ofs <= n_ofs;
        r_rbank <= n_rbank; r_rel <= n_rel;     r_o_st <= n_o_st;   r_o_nh <= n_o_nh;
        r_o_ofs <= n_o_ofs; r_o_bank <= n_o_bank; r_o_rel <= n_o_rel;
        r_o_comp <= n_o_comp;
    end

    assign o_in_stall   = (r_state != rca_pkg::S_IDLE);
    assign o_out_valid  = r_ovld;
    assign o_status     = r_o_st;
    assign o_new_handle = r_o_nh;
    assign o_obj_offset = r_o_ofs;
    assign o_obj_bank   = r_o_bank;
    assign o_released   = r_o_rel;
    assign o_compacted  = r_o_comp;

    `ASSERT_ALWAYS(a_live_bound, i_clk, i_rst_n, r_live <= LW'(MAX_OBJECTS), "live over size")
    `ASSERT_IMPLY(a_idle_empty, i_clk, i_rst_n, !r_ready, r_live == '0, "entries held idle")
    `ASSERT_IMPLY(a_ins_room, i_clk, i_rst_n, w_ctl.insert, r_live < LW'(MAX_OBJECTS), "full")
    `ASSERT_IMPLY(a_rem_found, i_clk, i_rst_n, w_ctl.remove, r_found && r_live != '0, "no entry")

endmodule
